[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define YT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define YT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define YT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define YT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

[hw/rtl/ytpq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ytpq_pkg
// Shared constants and types of the Young tableau priority queue.
// ----------------------------------------------------------------------------
package ytpq_pkg;

  localparam int MAX_ROWS_DEF = 16;
  localparam int MAX_COLS_DEF = 16;

  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam int VAL_W     = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;
  localparam logic [CFG_W-1:0]     CFG_RESET = 5'd16;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  localparam logic [VAL_W-1:0] EMPTY_MARK   = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] SIGN_BIT     = 32'h8000_0000;
  // cells are stored sign-flipped so that an unsigned compare orders them
  localparam logic [VAL_W-1:0] EMPTY_BIASED = EMPTY_MARK ^ SIGN_BIT;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } ytpq_status_t;

  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] value;
    ytpq_status_t     status;
  } ytpq_result_t;

endpackage

[hw/rtl/ytpq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ytpq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module ytpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[hw/rtl/ytpq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ytpq_ctrl
// Sequencer: clearing pass, empty-cell scan, sift-up and sift-down walks.
// ----------------------------------------------------------------------------
module ytpq_ctrl #(
  parameter int MAX_ROWS = ytpq_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = ytpq_pkg::MAX_COLS_DEF,
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int DEPTH = MAX_ROWS * MAX_COLS,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       in_operation,
  input  logic [ytpq_pkg::VAL_W-1:0] in_value,
  input  logic [RW-1:0]              rows_last,
  input  logic [CW-1:0]              cols_last,
  output logic                       busy,
  output ytpq_pkg::ytpq_result_t     result,
  output logic                       mem_we,
  output logic [AW-1:0]              mem_waddr,
  output logic [ytpq_pkg::VAL_W-1:0] mem_wdata,
  output logic [AW-1:0]              mem_raddr_a,
  output logic [AW-1:0]              mem_raddr_b,
  input  logic [ytpq_pkg::VAL_W-1:0] mem_rdata_a,
  input  logic [ytpq_pkg::VAL_W-1:0] mem_rdata_b
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_UP_RD  = 8'b0000_1000,
    S_UP_CMP = 8'b0001_0000,
    S_EX_CMP = 8'b0010_0000,
    S_DN_RD  = 8'b0100_0000,
    S_DN_CMP = 8'b1000_0000
  } state_t;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    cell_addr = AW'(r) * AW'(MAX_COLS) + AW'(c);
  endfunction

  state_t                       state_r, state_nxt;
  logic [AW-1:0]                clr_cnt_r, clr_cnt_nxt;
  logic [RW-1:0]                rlast_r, rlast_nxt;
  logic [CW-1:0]                clast_r, clast_nxt;
  logic [RW-1:0]                row_r, row_nxt;
  logic [CW-1:0]                col_r, col_nxt;
  logic [RW-1:0]                sr_r, sr_nxt;
  logic [CW-1:0]                sc_r, sc_nxt;
  logic [RW-1:0]                tag_row_r, tag_row_nxt;
  logic [CW-1:0]                tag_col_r, tag_col_nxt;
  logic                         tag_last_r, tag_last_nxt;
  logic                         tag_v_r, tag_v_nxt;
  logic                         issue_done_r, issue_done_nxt;
  logic [ytpq_pkg::VAL_W-1:0]   here_r, here_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [ytpq_pkg::VAL_W-1:0]   out_value_r, out_value_nxt;
  ytpq_pkg::ytpq_status_t       out_status_r, out_status_nxt;

  logic                         has_up, has_left, has_down, has_right;
  logic                         go_first;
  logic [ytpq_pkg::VAL_W-1:0]   nb_val;
  logic [ytpq_pkg::VAL_W-1:0]   ins_val;

  assign has_up    = (row_r != '0);
  assign has_left  = (col_r != '0);
  assign has_down  = (row_r != rlast_r);
  assign has_right = (col_r != clast_r);

  // the empty marker cannot be stored as data; it saturates one below
  assign ins_val = ((in_value == ytpq_pkg::EMPTY_MARK) ? (ytpq_pkg::EMPTY_MARK - 32'd1)
                                                        : in_value) ^ ytpq_pkg::SIGN_BIT;

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    rlast_nxt      = rlast_r;
    clast_nxt      = clast_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    sr_nxt         = sr_r;
    sc_nxt         = sc_r;
    tag_row_nxt    = tag_row_r;
    tag_col_nxt    = tag_col_r;
    tag_last_nxt   = tag_last_r;
    tag_v_nxt      = tag_v_r;
    issue_done_nxt = issue_done_r;
    here_nxt       = here_r;
    out_valid_nxt  = 1'b0;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_waddr      = cell_addr(row_r, col_r);
    mem_wdata      = here_r;
    mem_raddr_a    = '0;  // corner read while idle
    mem_raddr_b    = '0;
    go_first       = 1'b0;
    nb_val         = mem_rdata_b;

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = ytpq_pkg::EMPTY_BIASED;
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + AW'(1);
        end
      end

      S_IDLE: begin
        if (start) begin
          rlast_nxt = rows_last;
          clast_nxt = cols_last;
          case (in_operation)
            ytpq_pkg::OP_INSERT: begin
              here_nxt       = ins_val;
              sr_nxt         = '0;
              sc_nxt         = '0;
              tag_v_nxt      = 1'b0;
              issue_done_nxt = 1'b0;
              out_value_nxt  = ytpq_pkg::EMPTY_MARK;
              state_nxt      = S_SCAN;
            end
            ytpq_pkg::OP_EXTRACT: begin
              state_nxt = S_EX_CMP;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // one read issued per cycle, checked in the next cycle against its tag
        mem_raddr_a = cell_addr(sr_r, sc_r);
        tag_v_nxt   = !issue_done_r;
        if (!issue_done_r) begin
          tag_row_nxt  = sr_r;
          tag_col_nxt  = sc_r;
          tag_last_nxt = (sr_r == rlast_r) && (sc_r == clast_r);
          if (sc_r == clast_r) begin
            sc_nxt = '0;
            if (sr_r == rlast_r) begin
              issue_done_nxt = 1'b1;
            end else begin
              sr_nxt = sr_r + RW'(1);
            end
          end else begin
            sc_nxt = sc_r + CW'(1);
          end
        end
        if (tag_v_r && (mem_rdata_a == ytpq_pkg::EMPTY_BIASED)) begin
          row_nxt   = tag_row_r;
          col_nxt   = tag_col_r;
          state_nxt = S_UP_RD;
        end else if (tag_v_r && tag_last_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ytpq_pkg::ST_FULL;
          state_nxt      = S_IDLE;
        end
      end

      S_UP_RD: begin
        mem_raddr_a = cell_addr(has_up ? (row_r - RW'(1)) : row_r, col_r);
        mem_raddr_b = cell_addr(row_r, has_left ? (col_r - CW'(1)) : col_r);
        if (!has_up && !has_left) begin
          mem_we         = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ytpq_pkg::ST_DONE;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        // a = up, b = left; up wins a tie
        go_first = has_up && (!has_left || (mem_rdata_a >= mem_rdata_b));
        nb_val   = go_first ? mem_rdata_a : mem_rdata_b;
        mem_we   = 1'b1;
        if (nb_val < here_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ytpq_pkg::ST_DONE;
          state_nxt      = S_IDLE;
        end else begin
          // moving value stays in here_r; only the neighbor is written back
          mem_wdata = nb_val;
          if (go_first) begin
            row_nxt = row_r - RW'(1);
          end else begin
            col_nxt = col_r - CW'(1);
          end
          state_nxt = S_UP_RD;
        end
      end

      S_EX_CMP: begin
        if (mem_rdata_a == ytpq_pkg::EMPTY_BIASED) begin
          out_value_nxt  = ytpq_pkg::EMPTY_MARK;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ytpq_pkg::ST_EMPTY;
          state_nxt      = S_IDLE;
        end else begin
          out_value_nxt = mem_rdata_a ^ ytpq_pkg::SIGN_BIT;
          here_nxt      = ytpq_pkg::EMPTY_BIASED;
          row_nxt       = '0;
          col_nxt       = '0;
          state_nxt     = S_DN_RD;
        end
      end

      S_DN_RD: begin
        mem_raddr_a = cell_addr(has_down ? (row_r + RW'(1)) : row_r, col_r);
        mem_raddr_b = cell_addr(row_r, has_right ? (col_r + CW'(1)) : col_r);
        if (!has_down && !has_right) begin
          mem_we         = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ytpq_pkg::ST_DONE;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_DN_CMP;
        end
      end

      S_DN_CMP: begin
        // a = down, b = right; down wins a tie
        go_first = has_down && (!has_right || (mem_rdata_a <= mem_rdata_b));
        nb_val   = go_first ? mem_rdata_a : mem_rdata_b;
        mem_we   = 1'b1;
        if (nb_val > here_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ytpq_pkg::ST_DONE;
          state_nxt      = S_IDLE;
        end else begin
          mem_wdata = nb_val;
          if (go_first) begin
            row_nxt = row_r + RW'(1);
          end else begin
            col_nxt = col_r + CW'(1);
          end
          state_nxt = S_DN_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      tag_v_r      <= 1'b0;
      issue_done_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      tag_v_r      <= tag_v_nxt;
      issue_done_r <= issue_done_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rlast_r      <= rlast_nxt;
    clast_r      <= clast_nxt;
    row_r        <= row_nxt;
    col_r        <= col_nxt;
    sr_r         <= sr_nxt;
    sc_r         <= sc_nxt;
    tag_row_r    <= tag_row_nxt;
    tag_col_r    <= tag_col_nxt;
    tag_last_r   <= tag_last_nxt;
    here_r       <= here_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign result.valid  = out_valid_r;
  assign result.value  = out_value_r;
  assign result.status = out_status_r;

endmodule

[hw/rtl/young_tableau_priority_queue_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// young_tableau_priority_queue_top
// Young tableau priority queue: insert and extract-min over one cell RAM.
// ----------------------------------------------------------------------------
// Channel   Ports                                  Handshake
// input     in_operation, in_value                 start && !busy
// result    out_result_value, out_status           out_valid, one cycle
// config    cfg_index, cfg_wdata                   cfg_we
//
// Reset runs a clearing pass (busy high) that writes the empty marker into
// each of the MAX_ROWS*MAX_COLS cells; config writes are taken meanwhile.
// Insert: a row-major scan up to the first free cell (over the whole area
// when full), then one read-and-compare step per swap and a finishing write.
// Extract: a corner check, then, when not empty, always rows+cols-2 swaps
// and a finishing write. The strobe comes the cycle busy falls; no stalls.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module young_tableau_priority_queue_top #(
  parameter int MAX_ROWS = ytpq_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = ytpq_pkg::MAX_COLS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_operation,
  input  logic signed [ytpq_pkg::VAL_W-1:0]  in_value,
  output logic                               out_valid,
  output logic signed [ytpq_pkg::VAL_W-1:0]  out_result_value,
  output logic [1:0]                         out_status,
  input  logic                               cfg_we,
  input  logic [ytpq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ytpq_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ytpq_pkg::CFG_W-1:0] rows_used_r;
  logic [ytpq_pkg::CFG_W-1:0] cols_used_r;
  logic [RW-1:0]              rows_last;
  logic [CW-1:0]              cols_last;
  ytpq_pkg::ytpq_result_t     result;

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [ytpq_pkg::VAL_W-1:0] mem_wdata;
  logic [AW-1:0]              mem_raddr_a;
  logic [AW-1:0]              mem_raddr_b;
  logic [ytpq_pkg::VAL_W-1:0] mem_rdata_a;
  logic [ytpq_pkg::VAL_W-1:0] mem_rdata_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_used_r <= ytpq_pkg::CFG_RESET;
      cols_used_r <= ytpq_pkg::CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ytpq_pkg::CFG_ROWS: rows_used_r <= cfg_wdata;
        ytpq_pkg::CFG_COLS: cols_used_r <= cfg_wdata;
        default: begin
          rows_used_r <= rows_used_r;
        end
      endcase
    end
  end

  // zero acts as one, anything above the maximum as the maximum
  always_comb begin
    if (rows_used_r == '0) begin
      rows_last = '0;
    end else if (int'(rows_used_r) > MAX_ROWS) begin
      rows_last = RW'(MAX_ROWS - 1);
    end else begin
      rows_last = RW'(rows_used_r - 5'd1);
    end
    if (cols_used_r == '0) begin
      cols_last = '0;
    end else if (int'(cols_used_r) > MAX_COLS) begin
      cols_last = CW'(MAX_COLS - 1);
    end else begin
      cols_last = CW'(cols_used_r - 5'd1);
    end
  end

  ytpq_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .in_value     (in_value),
    .rows_last    (rows_last),
    .cols_last    (cols_last),
    .busy         (busy),
    .result       (result),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr_a  (mem_raddr_a),
    .mem_raddr_b  (mem_raddr_b),
    .mem_rdata_a  (mem_rdata_a),
    .mem_rdata_b  (mem_rdata_b)
  );

  ytpq_ram #(
    .WIDTH (ytpq_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  assign out_valid        = result.valid;
  assign out_result_value = $signed(result.value);
  assign out_status       = result.status;

  `YT_ASSERT_IMP(a_result_after_work, clk, rst_n, out_valid, $past(busy), "result without prior work")
  `YT_ASSERT_NXT(a_accept_goes_busy, clk, rst_n, start && !busy, busy, "accepted request not busy")
  `YT_ASSERT_NXT(a_no_spurious_result, clk, rst_n, !busy && !start, !out_valid, "result with no request")
  `YT_ASSERT_IMP(a_full_no_value, clk, rst_n, out_valid && (out_status == ytpq_pkg::ST_FULL), out_result_value == $signed(ytpq_pkg::EMPTY_MARK), "full insert returned a value")

endmodule

[tb/young_tableau_priority_queue_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// young_tableau_priority_queue_top_tb
// Self-checking bench for the Young tableau insert / extract-min queue.
// A scripted opening covers empty and full tables, marker saturation and a
// shrunk area. Random traffic then runs over many area settings, with sender
// gaps, and a 16x16 fill-and-drain. Every reply is checked against a
// tableau model held in the bench or against a scripted expected reply.
// ----------------------------------------------------------------------------
module young_tableau_priority_queue_top_tb;

  localparam int TB_ROWS = ytpq_pkg::MAX_ROWS_DEF;
  localparam int TB_COLS = ytpq_pkg::MAX_COLS_DEF;
  localparam logic signed [ytpq_pkg::VAL_W-1:0] FREE_CELL = ytpq_pkg::EMPTY_MARK;
  localparam logic signed [ytpq_pkg::VAL_W-1:0] MOST_NEG  = ytpq_pkg::SIGN_BIT;
  localparam int MAX_REPORTS = 10;
  localparam int SETTLE_CYCLES = 400;

  typedef struct {
    logic signed [ytpq_pkg::VAL_W-1:0] value;
    ytpq_pkg::ytpq_status_t            status;
  } reply_t;

  typedef struct {
    bit                                area;
    logic                              op;
    logic signed [ytpq_pkg::VAL_W-1:0] value;
    logic [ytpq_pkg::CFG_W-1:0]        rows;
    logic [ytpq_pkg::CFG_W-1:0]        cols;
    bit                                typed;
    reply_t                            want;
  } script_row_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic                              in_operation = ytpq_pkg::OP_INSERT;
  logic signed [ytpq_pkg::VAL_W-1:0] in_value = '0;
  logic                              out_valid;
  logic signed [ytpq_pkg::VAL_W-1:0] out_result_value;
  logic [1:0]                        out_status;
  logic                              cfg_we = 1'b0;
  logic [ytpq_pkg::CFG_IDX_W-1:0]    cfg_index = ytpq_pkg::CFG_ROWS;
  logic [ytpq_pkg::CFG_W-1:0]        cfg_wdata = '0;

  // tableau model state
  logic signed [ytpq_pkg::VAL_W-1:0] tableau [TB_ROWS][TB_COLS];
  logic [ytpq_pkg::CFG_W-1:0]        area_rows = ytpq_pkg::CFG_RESET;
  logic [ytpq_pkg::CFG_W-1:0]        area_cols = ytpq_pkg::CFG_RESET;

  reply_t      pending_replies[$];
  script_row_t script[$];
  int          error_count = 0;
  int          send_idle_pct = 7;

  young_tableau_priority_queue_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #30_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int used_dim(input logic [ytpq_pkg::CFG_W-1:0] setting,
                                  input int limit);
    if (setting == '0) return 1;
    if (int'(setting) > limit) return limit;
    return int'(setting);
  endfunction

  // Applies one request to the model tableau and returns the reply it gives.
  function automatic reply_t tableau_apply(input logic op,
                                           input logic signed [ytpq_pkg::VAL_W-1:0] val);
    reply_t                            rep;
    int                                rows, cols, r, c, nr, nc, i;
    bit                                found, vertical, moving;
    logic signed [ytpq_pkg::VAL_W-1:0] tmp;
    rows = used_dim(area_rows, TB_ROWS);
    cols = used_dim(area_cols, TB_COLS);
    rep.value = FREE_CELL;
    rep.status = ytpq_pkg::ST_DONE;
    r = 0;
    c = 0;
    if (op == ytpq_pkg::OP_INSERT) begin
      found = 1'b0;
      for (i = 0; i < rows * cols && !found; i++) begin
        if (tableau[i / cols][i % cols] == FREE_CELL) begin
          found = 1'b1;
          r = i / cols;
          c = i % cols;
        end
      end
      if (!found) begin
        rep.status = ytpq_pkg::ST_FULL;
      end else begin
        // the marker itself may not be stored
        tableau[r][c] = (val == FREE_CELL) ? FREE_CELL - 1 : val;
        moving = 1'b1;
        while (moving && (r > 0 || c > 0)) begin
          if (r > 0 && c > 0) vertical = tableau[r-1][c] >= tableau[r][c-1];
          else vertical = (r > 0);
          nr = vertical ? r - 1 : r;
          nc = vertical ? c : c - 1;
          if (tableau[nr][nc] < tableau[r][c]) begin
            moving = 1'b0;
          end else begin
            tmp = tableau[nr][nc];
            tableau[nr][nc] = tableau[r][c];
            tableau[r][c] = tmp;
            r = nr;
            c = nc;
          end
        end
      end
    end else if (tableau[0][0] == FREE_CELL) begin
      rep.status = ytpq_pkg::ST_EMPTY;
    end else begin
      rep.value = tableau[0][0];
      tableau[0][0] = FREE_CELL;
      moving = 1'b1;
      // hole sinks toward the smaller neighbor, down on a tie
      while (moving && (r + 1 < rows || c + 1 < cols)) begin
        if (r + 1 < rows && c + 1 < cols) vertical = tableau[r+1][c] <= tableau[r][c+1];
        else vertical = (r + 1 < rows);
        nr = vertical ? r + 1 : r;
        nc = vertical ? c : c + 1;
        if (tableau[nr][nc] > tableau[r][c]) begin
          moving = 1'b0;
        end else begin
          tmp = tableau[nr][nc];
          tableau[nr][nc] = tableau[r][c];
          tableau[r][c] = tmp;
          r = nr;
          c = nc;
        end
      end
    end
    return rep;
  endfunction

  function automatic logic signed [ytpq_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return MOST_NEG;
      1:       return FREE_CELL - 1;
      2:       return FREE_CELL;
      3, 4:    return $urandom_range(8) - 4;   // narrow range, plenty of ties
      5:       return $urandom_range(1) ? 32'sd0 : -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [ytpq_pkg::CFG_W-1:0] pick_dim();
    case ($urandom_range(9))
      0:       return '0;
      1:       return ytpq_pkg::CFG_W'($urandom_range(31, 17));
      2:       return 5'd16;
      3:       return 5'd1;
      default: return ytpq_pkg::CFG_W'($urandom_range(5, 2));
    endcase
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("mismatch @%0t: %s", $realtime, msg);
  endtask

  task automatic enqueue_reply(input reply_t rep);
    pending_replies.insert(pending_replies.size(), rep);
  endtask

  task automatic add_req(input logic op, input logic signed [ytpq_pkg::VAL_W-1:0] val);
    script_row_t row;
    row.area = 1'b0;
    row.op = op;
    row.value = val;
    row.rows = '0;
    row.cols = '0;
    row.typed = 1'b0;
    row.want.value = FREE_CELL;
    row.want.status = ytpq_pkg::ST_DONE;
    script.insert(script.size(), row);
  endtask

  task automatic add_checked(input logic op, input logic signed [ytpq_pkg::VAL_W-1:0] val,
                             input logic signed [ytpq_pkg::VAL_W-1:0] want_value,
                             input ytpq_pkg::ytpq_status_t want_status);
    add_req(op, val);
    script[$].typed = 1'b1;
    script[$].want.value = want_value;
    script[$].want.status = want_status;
  endtask

  task automatic add_area(input logic [ytpq_pkg::CFG_W-1:0] rows,
                          input logic [ytpq_pkg::CFG_W-1:0] cols);
    add_req(ytpq_pkg::OP_INSERT, '0);
    script[$].area = 1'b1;
    script[$].rows = rows;
    script[$].cols = cols;
  endtask

  // Holds a request on the port until it is taken; start drops in idle cycles.
  task automatic send_request(input logic op, input logic signed [ytpq_pkg::VAL_W-1:0] val);
    bit go;
    in_operation <= op;
    in_value <= val;
    do begin
      go = ($urandom_range(99) >= send_idle_pct);
      start <= go;
      @(posedge clk);
    end while (!(go && !busy));
  endtask

  task automatic set_area(input logic [ytpq_pkg::CFG_W-1:0] rows,
                          input logic [ytpq_pkg::CFG_W-1:0] cols);
    start <= 1'b0;
    while (pending_replies.size() != 0 || busy) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= ytpq_pkg::CFG_ROWS;
    cfg_wdata <= rows;
    @(posedge clk);
    cfg_index <= ytpq_pkg::CFG_COLS;
    cfg_wdata <= cols;
    @(posedge clk);
    cfg_we <= 1'b0;
    area_rows = rows;
    area_cols = cols;
    @(posedge clk);
  endtask

  task automatic run_traffic(input int count, input int insert_pct);
    logic                              op;
    logic signed [ytpq_pkg::VAL_W-1:0] val;
    repeat (count) begin
      op = ($urandom_range(99) < insert_pct) ? ytpq_pkg::OP_INSERT : ytpq_pkg::OP_EXTRACT;
      val = pick_value();
      send_request(op, val);
      enqueue_reply(tableau_apply(op, val));
    end
  endtask

  task automatic run_small_segments(input int budget);
    int n;
    while (budget > 0) begin
      set_area(pick_dim(), pick_dim());
      n = $urandom_range(60, 20);
      if (n > budget) n = budget;
      case ($urandom_range(2))
        0:       run_traffic(n, 25);
        1:       run_traffic(n, 50);
        default: run_traffic(n, 75);
      endcase
      budget -= n;
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        flag_error($sformatf("reply with none pending: value %0d status %0d",
                             out_result_value, out_status));
      end else begin
        want = pending_replies.pop_front();
        if (out_result_value !== want.value)
          flag_error($sformatf("value exp %0d got %0d", want.value, out_result_value));
        if (out_status !== want.status)
          flag_error($sformatf("status exp %0d got %0d", want.status, out_status));
      end
    end
  end

  initial begin
    reply_t model_reply;
    int     guard;
    for (int r = 0; r < TB_ROWS; r++)
      for (int c = 0; c < TB_COLS; c++)
        tableau[r][c] = FREE_CELL;

    add_checked(ytpq_pkg::OP_EXTRACT, '0, FREE_CELL, ytpq_pkg::ST_EMPTY);
    add_checked(ytpq_pkg::OP_INSERT, FREE_CELL, FREE_CELL, ytpq_pkg::ST_DONE);
    add_checked(ytpq_pkg::OP_EXTRACT, '0, FREE_CELL - 1, ytpq_pkg::ST_DONE);
    add_checked(ytpq_pkg::OP_INSERT, MOST_NEG, FREE_CELL, ytpq_pkg::ST_DONE);
    add_checked(ytpq_pkg::OP_INSERT, 32'sd5, FREE_CELL, ytpq_pkg::ST_DONE);
    add_checked(ytpq_pkg::OP_INSERT, 32'sd5, FREE_CELL, ytpq_pkg::ST_DONE);
    add_checked(ytpq_pkg::OP_INSERT, -32'sd1, FREE_CELL, ytpq_pkg::ST_DONE);
    add_checked(ytpq_pkg::OP_EXTRACT, -32'sd1, MOST_NEG, ytpq_pkg::ST_DONE);
    add_req(ytpq_pkg::OP_EXTRACT, '0);
    add_req(ytpq_pkg::OP_EXTRACT, '0);
    add_req(ytpq_pkg::OP_EXTRACT, '0);
    add_checked(ytpq_pkg::OP_EXTRACT, '0, FREE_CELL, ytpq_pkg::ST_EMPTY);
    add_area(5'd0, 5'd0);                  // zero acts as one
    add_checked(ytpq_pkg::OP_INSERT, 32'sd7, FREE_CELL, ytpq_pkg::ST_DONE);
    add_checked(ytpq_pkg::OP_INSERT, 32'sd8, FREE_CELL, ytpq_pkg::ST_FULL);
    add_checked(ytpq_pkg::OP_EXTRACT, '0, 32'sd7, ytpq_pkg::ST_DONE);
    add_area(5'd1, 5'd2);
    add_req(ytpq_pkg::OP_INSERT, 32'sd3);
    add_req(ytpq_pkg::OP_INSERT, 32'sd1);
    add_area(5'd1, 5'd1);                  // 3 left stranded outside the area
    add_checked(ytpq_pkg::OP_INSERT, 32'sd9, FREE_CELL, ytpq_pkg::ST_FULL);
    add_checked(ytpq_pkg::OP_EXTRACT, '0, 32'sd1, ytpq_pkg::ST_DONE);
    add_area(5'd1, 5'd2);
    add_req(ytpq_pkg::OP_EXTRACT, '0);     // empty corner beside a stored entry
    add_area(5'd31, 5'd31);
    add_req(ytpq_pkg::OP_INSERT, '0);
    add_req(ytpq_pkg::OP_EXTRACT, '0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].area) begin
        set_area(script[i].rows, script[i].cols);
      end else begin
        send_request(script[i].op, script[i].value);
        model_reply = tableau_apply(script[i].op, script[i].value);
        enqueue_reply(script[i].typed ? script[i].want : model_reply);
      end
    end

    send_idle_pct = 7;
    run_small_segments(450);
    send_idle_pct = 76;
    run_small_segments(450);
    send_idle_pct = 0;
    run_small_segments(150);
    // full-size fill past capacity, then drain past empty
    set_area(5'd16, 5'd16);
    run_traffic(280, 100);
    run_traffic(270, 0);

    start <= 1'b0;
    for (guard = 0; guard < 2000 && pending_replies.size() != 0; guard++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_replies.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[young_tableau_priority_queue_top.f]
+incdir+hw/rtl
hw/rtl/ytpq_pkg.sv
hw/rtl/ytpq_ram.sv
hw/rtl/ytpq_ctrl.sv
hw/rtl/young_tableau_priority_queue_top.sv
tb/young_tableau_priority_queue_top_tb.sv
